@@ rtl/dpt_pkg.sv @@
// shared constants, log table and helper function for the dew point block
`default_nettype none

package dpt_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int TC_W  = 15;
  localparam int HUM_W = 14;
  localparam int DP_W  = 15;

  localparam int DP_MIN   = -12000;
  localparam int DP_MAX   = 8500;
  localparam int HUM_FULL = 10000;
  localparam int B_CENTI  = 1762;
  localparam int C_CENTI  = 24312;
  localparam int HUND     = 100;

  localparam int LN_PTS = 17;
  localparam int NANO_W = 30;

  // ln(1 + i/16) in units of 1e-9
  localparam logic [NANO_W-1:0] LN_NANO [LN_PTS] = '{
    30'd0,         30'd60624622,  30'd117783036, 30'd171850257,
    30'd223143551, 30'd271933715, 30'd318453731, 30'd362905494,
    30'd405465108, 30'd446287103, 30'd485507816, 30'd523248144,
    30'd559615788, 30'd594707108, 30'd628608659, 30'd661398482,
    30'd693147181
  };

  function automatic longint to_q(input logic [NANO_W-1:0] nano, input int frac);
    logic [63:0] t;
    t = (64'(nano) << frac) + 64'd500000000;
    return longint'(t / 64'd1000000000);
  endfunction

endpackage

`default_nettype wire

@@ rtl/dpt_div_cell.sv @@
// one restoring division step: decides a single quotient bit and passes on
`default_nettype none

module dpt_div_cell import dpt_pkg::*; #(
  parameter int PW  = 40,
  parameter int DW  = 22,
  parameter int QW  = 18,
  parameter int SW  = 2,
  parameter int BIT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [PW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [QW-1:0] quo_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [PW-1:0] rem_o,
  output logic [DW-1:0] den_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [PW:0]   trial;
  logic          take;
  logic          valid_q;
  logic [PW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q;
  logic [QW-1:0] quo_q, quo_d;
  logic [SW-1:0] side_q;

  always_comb begin
    trial = (PW+1)'(rem_i) - ((PW+1)'(den_i) << BIT);
    take  = !trial[PW];
    rem_d = take ? trial[PW-1:0] : rem_i;
    quo_d = quo_i;
    if (take) begin
      quo_d[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_i;
    quo_q  <= quo_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

@@ rtl/dpt_div_chain.sv @@
// row of division cells, one quotient bit per cell, one word enters per cycle
`default_nettype none

module dpt_div_chain import dpt_pkg::*; #(
  parameter int NW = 40,
  parameter int DW = 22,
  parameter int QW = 18,
  parameter int SW = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  localparam int PW = DW + QW;

  logic          v_c    [QW+1];
  logic [PW-1:0] rem_c  [QW+1];
  logic [DW-1:0] den_c  [QW+1];
  logic [QW-1:0] quo_c  [QW+1];
  logic [SW-1:0] side_c [QW+1];

  assign v_c[0]    = valid_i;
  assign rem_c[0]  = PW'(num_i);
  assign den_c[0]  = den_i;
  assign quo_c[0]  = '0;
  assign side_c[0] = side_i;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    dpt_div_cell #(
      .PW (PW),
      .DW (DW),
      .QW (QW),
      .SW (SW),
      .BIT(QW - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(v_c[k]),
      .rem_i  (rem_c[k]),
      .den_i  (den_c[k]),
      .quo_i  (quo_c[k]),
      .side_i (side_c[k]),
      .valid_o(v_c[k+1]),
      .rem_o  (rem_c[k+1]),
      .den_o  (den_c[k+1]),
      .quo_o  (quo_c[k+1]),
      .side_o (side_c[k+1])
    );
  end

  assign valid_o = v_c[QW];
  assign quo_o   = quo_c[QW];
  assign side_o  = side_c[QW];

endmodule

`default_nettype wire

@@ rtl/dpt_ln.sv @@
// natural log of humidity relative to full scale, table with interpolation
`default_nettype none

module dpt_ln import dpt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int LW        = FRAC_BITS + 5
) (
  input  logic [HUM_W-1:0]     hum_i,
  output logic signed [LW-1:0] ln_rel_o
);

  localparam int TW = FRAC_BITS;

  function automatic logic [LN_PTS*TW-1:0] build_tab();
    logic [LN_PTS*TW-1:0] t;
    t = '0;
    for (int i = 0; i < LN_PTS; i++) begin
      t[i*TW +: TW] = TW'(to_q(LN_NANO[i], FRAC_BITS));
    end
    return t;
  endfunction

  function automatic longint ln_const(input int h);
    int     e;
    int     r;
    int     sc;
    int     idx;
    int     rm;
    longint lo;
    longint hi;
    e = 0;
    for (int i = 1; i < HUM_W; i++) begin
      if (((h >> i) & 1) != 0) e = i;
    end
    r   = h - (1 << e);
    sc  = r << 4;
    idx = (sc >> e) & 15;
    rm  = sc & ((1 << e) - 1);
    lo  = to_q(LN_NANO[idx], FRAC_BITS);
    hi  = to_q(LN_NANO[idx+1], FRAC_BITS);
    return longint'(e) * to_q(LN_NANO[LN_PTS-1], FRAC_BITS) + lo
           + (((hi - lo) * longint'(rm)) >>> e);
  endfunction

  localparam logic [LN_PTS*TW-1:0] TAB     = build_tab();
  localparam longint               LN_FULL = ln_const(HUM_FULL);
  localparam logic [TW-1:0]        LN_TWO  = TAB[(LN_PTS-1)*TW +: TW];

  logic [3:0]        e;
  logic [HUM_W-1:0]  r;
  logic [HUM_W+3:0]  scaled;
  logic [3:0]        idx;
  logic [4:0]        idx_hi;
  logic [12:0]       rem;
  logic [TW-1:0]     lo, hi, diff;
  logic [TW+12:0]    prod;
  logic [TW-1:0]     frac;
  logic [TW+4:0]     sum;

  always_comb begin
    e = '0;
    for (int i = 1; i < HUM_W; i++) begin
      if (hum_i[i]) e = 4'(i);
    end
    r       = hum_i & ~(HUM_W'(1) << e);
    scaled  = {r, 4'b0000};
    idx     = 4'(scaled >> e);
    idx_hi  = {1'b0, idx} + 5'd1;
    rem     = 13'(scaled & ((18'(1) << e) - 18'(1)));
    lo      = TAB[idx*TW +: TW];
    hi      = TAB[idx_hi*TW +: TW];
    diff    = hi - lo;
    prod    = (TW+13)'(diff) * (TW+13)'(rem);
    frac    = TW'(prod >> e);
    sum     = (TW+5)'(LN_TWO) * (TW+5)'(e) + (TW+5)'(lo) + (TW+5)'(frac);
    ln_rel_o = signed'(LW'(sum)) - LW'(LN_FULL);
  end

endmodule

`default_nettype wire

@@ rtl/dew_point_from_temp_humidity.sv @@
// dew point from temperature and humidity, magnus formula, top level
//
// channel   direction  handshake          word
// command   in         start_i, busy_o    temperature_centi_i, humidity_centi_i
// result    out        done_o             dew_point_centi_o, humidity_invalid_o, clipped_o
//
// one word is taken every cycle; busy_o stays low
// each word passes through two division rows of FRAC_BITS + 6 and 17 cells,
// plus four arithmetic stages
// reset clears the valid bits of every stage; no clearing pass
// done_o is a one-cycle strobe and the receiver cannot stall the block
`default_nettype none

module dew_point_from_temp_humidity import dpt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [TC_W-1:0]  temperature_centi_i,
  input  logic [HUM_W-1:0]        humidity_centi_i,
  output logic                    done_o,
  output logic signed [DP_W-1:0]  dew_point_centi_o,
  output logic                    humidity_invalid_o,
  output logic                    clipped_o
);

  localparam int LW  = FRAC_BITS + 5;
  localparam int N1W = FRAC_BITS + 25;
  localparam int D1W = 22;
  localparam int Q1W = FRAC_BITS + 6;
  localparam int GW  = FRAC_BITS + 7;
  localparam int N2W = FRAC_BITS + 21;
  localparam int D2W = FRAC_BITS + 6;
  localparam int Q2W = 17;
  localparam int S1W = LW + 2;
  localparam int LAT = Q1W + Q2W + 4;
  localparam longint BQ = ((longint'(B_CENTI) << FRAC_BITS) + longint'(HUND / 2))
                          / longint'(HUND);

  // input stage
  logic [HUM_W-1:0]     hum_c;
  logic signed [LW-1:0] ln_rel;
  logic signed [26:0]   t_prod;
  logic [25:0]          t_mag;
  logic signed [16:0]   t_base;
  logic [D1W-1:0]       d1;
  logic [N1W-1:0]       n1;

  logic                 s0_v_q;
  logic [N1W-1:0]       s0_num_q;
  logic [D1W-1:0]       s0_den_q;
  logic [S1W-1:0]       s0_side_q;

  assign busy_o = 1'b0;

  always_comb begin
    if (humidity_centi_i == '0) begin
      hum_c = HUM_W'(1);
    end else if (humidity_centi_i > HUM_W'(HUM_FULL)) begin
      hum_c = HUM_W'(HUM_FULL);
    end else begin
      hum_c = humidity_centi_i;
    end
    t_prod = 27'(temperature_centi_i) * 27'(B_CENTI);
    t_mag  = 26'(t_prod[26] ? -t_prod : t_prod);
    t_base = 17'(C_CENTI) + 17'(temperature_centi_i);
    d1     = D1W'(D1W'(t_base[15:0]) * D1W'(HUND));
    n1     = (N1W'(t_mag) << FRAC_BITS) + N1W'(d1 >> 1);
  end

  dpt_ln #(
    .FRAC_BITS(FRAC_BITS),
    .LW       (LW)
  ) u_ln (
    .hum_i   (hum_c),
    .ln_rel_o(ln_rel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else begin
      s0_v_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_num_q  <= n1;
    s0_den_q  <= d1;
    s0_side_q <= {(humidity_centi_i == '0), ln_rel, t_prod[26]};
  end

  // temperature term divider
  logic           dv1_v;
  logic [Q1W-1:0] dv1_q;
  logic [S1W-1:0] dv1_side;

  dpt_div_chain #(
    .NW(N1W),
    .DW(D1W),
    .QW(Q1W),
    .SW(S1W)
  ) u_div_term (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s0_v_q),
    .num_i  (s0_num_q),
    .den_i  (s0_den_q),
    .side_i (s0_side_q),
    .valid_o(dv1_v),
    .quo_o  (dv1_q),
    .side_o (dv1_side)
  );

  // gm = ln + term
  logic signed [GW-1:0] term_u, term, gm_d;
  logic                 sg_v_q, sg_inv_q;
  logic signed [GW-1:0] gm_q;

  always_comb begin
    term_u = GW'(dv1_q);
    term   = dv1_side[0] ? -term_u : term_u;
    gm_d   = GW'(signed'(dv1_side[LW:1])) + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sg_v_q <= 1'b0;
    end else begin
      sg_v_q <= dv1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    gm_q     <= gm_d;
    sg_inv_q <= dv1_side[S1W-1];
  end

  // dew point numerator and denominator
  logic signed [GW+15:0] n2_full;
  logic [N2W-1:0]        n2_mag;
  logic signed [GW-1:0]  d2_s;
  logic [D2W-1:0]        d2;
  logic                  sm_v_q;
  logic [N2W-1:0]        sm_num_q;
  logic [D2W-1:0]        sm_den_q;
  logic [1:0]            sm_side_q;

  always_comb begin
    n2_full = (GW+16)'(gm_q) * (GW+16)'(C_CENTI);
    n2_mag  = N2W'(n2_full[GW+15] ? -n2_full : n2_full);
    d2_s    = GW'(BQ) - gm_q;
    d2      = D2W'(d2_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_v_q <= 1'b0;
    end else begin
      sm_v_q <= sg_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sm_num_q  <= n2_mag + N2W'(d2 >> 1);
    sm_den_q  <= d2;
    sm_side_q <= {sg_inv_q, gm_q[GW-1]};
  end

  // dew point divider
  logic           dv2_v;
  logic [Q2W-1:0] dv2_q;
  logic [1:0]     dv2_side;

  dpt_div_chain #(
    .NW(N2W),
    .DW(D2W),
    .QW(Q2W),
    .SW(2)
  ) u_div_dew (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(sm_v_q),
    .num_i  (sm_num_q),
    .den_i  (sm_den_q),
    .side_i (sm_side_q),
    .valid_o(dv2_v),
    .quo_o  (dv2_q),
    .side_o (dv2_side)
  );

  // sign, saturation, invalid-humidity zeroing and output register
  logic signed [Q2W:0]   dp_u, dp_s;
  logic signed [DP_W-1:0] dp_d;
  logic                  clip_d;
  logic                  done_q, inv_q, clip_q;
  logic signed [DP_W-1:0] dp_q;

  always_comb begin
    dp_u   = (Q2W+1)'(dv2_q);
    dp_s   = dv2_side[0] ? -dp_u : dp_u;
    dp_d   = DP_W'(dp_s);
    clip_d = 1'b0;
    if (dp_s > (Q2W+1)'(DP_MAX)) begin
      dp_d   = DP_W'(DP_MAX);
      clip_d = 1'b1;
    end else if (dp_s < (Q2W+1)'(DP_MIN)) begin
      dp_d   = DP_W'(DP_MIN);
      clip_d = 1'b1;
    end
    if (dv2_side[1]) begin
      dp_d   = '0;
      clip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    dp_q   <= dp_d;
    inv_q  <= dv2_side[1];
    clip_q <= clip_d;
  end

  assign done_o             = done_q;
  assign dew_point_centi_o  = dp_q;
  assign humidity_invalid_o = inv_q;
  assign clipped_o          = clip_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LAT done_o)
    else $error("result missing after fixed latency");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##LAT !done_o)
    else $error("result without a command");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (dew_point_centi_o >= DP_W'(DP_MIN)) && (dew_point_centi_o <= DP_W'(DP_MAX)))
    else $error("dew point out of range");

  a_invalid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && humidity_invalid_o |-> (dew_point_centi_o == '0) && !clipped_o)
    else $error("invalid humidity word not zeroed");

  a_clip : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && clipped_o |-> (dew_point_centi_o == DP_W'(DP_MIN))
                            || (dew_point_centi_o == DP_W'(DP_MAX)))
    else $error("clipped word not at a bound");

endmodule

`default_nettype wire
